// File: rtl/tsst_pkg.sv
// Package for the transmit timestamp slot tracker: shared types, status codes,
// register indexes and the tick widening function. No dependencies.
package tsst_pkg;

   // Width of the tick fields carried by an arm transaction
   localparam int TICK_BITS = 29;

   // Register indexes on the CSR port (byte address = 4 * index)
   localparam logic [1:0] REG_STAMPING_ENABLE  = 2'd0;
   localparam logic [1:0] REG_OVERFLOW_MARGIN  = 2'd1;
   localparam logic [1:0] REG_MAX_RETRIES      = 2'd2;
   localparam logic [1:0] REG_UPDATE_THRESHOLD = 2'd3;

   // Reset values of the registers
   localparam logic [15:0] MARGIN_RESET    = 16'd100;
   localparam logic [7:0]  RETRIES_RESET   = 8'd10;
   localparam logic [31:0] THRESHOLD_RESET = 32'd1000;

   typedef enum logic {
      CMD_ARM  = 1'b0,
      CMD_POLL = 1'b1
   } cmd_type;

   typedef enum logic [3:0] {
      ST_ARMED   = 4'd0,
      ST_OFF     = 4'd1,
      ST_BUSY    = 4'd2,
      ST_RETRY   = 4'd3,
      ST_DONE    = 4'd4,
      ST_STALE   = 4'd5,
      ST_PARTIAL = 4'd6,
      ST_IDLE    = 4'd7,
      ST_BADSLOT = 4'd8
   } status_type;

   typedef struct packed {
      logic        stamping_enable;
      logic [15:0] overflow_margin;
      logic [7:0]  max_retries;
      logic [31:0] update_threshold;
   } cfg_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [3:0]             slot;
      logic [63:0]            now;
      logic [TICK_BITS-1:0]   from_tick;
      logic [TICK_BITS-1:0]   to_tick;
      logic [TICK_BITS-1:0]   delay_to_tick;
      logic                   retry_policy;
      logic [63:0]            captured_stamp;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [63:0] stamp;
   } result_type;

   // Join the high clock bits with the tick; step into the next tick period
   // when the tick lies more than the margin behind the low clock bits.
   function automatic logic [63:0] widen_tick(input logic [63:0]          now,
                                              input logic [TICK_BITS-1:0] tick,
                                              input logic [15:0]          margin);
      logic [TICK_BITS-1:0]  low;
      logic [TICK_BITS-1:0]  lag;
      logic [63-TICK_BITS:0] high;
      low  = now[TICK_BITS-1:0];
      lag  = low - tick;
      high = now[63:TICK_BITS];
      if (low > tick && {{(64-TICK_BITS){1'b0}}, lag} > {48'd0, margin}) begin
         high = high + {{(63-TICK_BITS){1'b0}}, 1'b1};
      end
      return {high, tick};
   endfunction

endpackage

// File: rtl/tx_timestamp_slot_tracker.sv
// Transmit timestamp slot tracker: one result per arm/poll transaction.
// Path: an accepted request goes into the input register, then the slot
// read-modify-write puts its result into the result register.
// Throughput: one transaction per cycle unless the response stream stalls; the slot update sets it.
// Reset clears busy flags, last stamps and retry counts and sets the registers to
// their reset values; window bounds are written when a slot is armed.
module tx_timestamp_slot_tracker #(
   parameter int SLOT_COUNT = 8
) (
   input  logic         clock,
   input  logic         reset,
   // Request stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: slot[3:0], now[67:4], from_tick[96:68], to_tick[125:97],
   //        delay_to_tick[154:126], retry_policy[155], captured_stamp[219:156]
   input  logic [223:0] req_tdata,
   // tuser: cmd[0]
   input  logic         req_tuser,
   // Response stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: stamp[63:0]
   output logic [63:0]  rsp_tdata,
   // tuser: status[3:0]
   output logic [3:0]   rsp_tuser,
   // CSR port
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import tsst_pkg::*;

   cfg_type    cfg;
   item_type   item_ff;
   item_type   item_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   result_type core_result;
   result_type result_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       req_fire;
   logic       advance;

   tsst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake: the item moves on whenever the result register is free or drains
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_fire   = req_tvalid & req_tready;

   // Unpack the request transaction
   always_comb begin
      item_in.cmd            = cmd_type'(req_tuser);
      item_in.slot           = req_tdata[3:0];
      item_in.now            = req_tdata[67:4];
      item_in.from_tick      = req_tdata[96:68];
      item_in.to_tick        = req_tdata[125:97];
      item_in.delay_to_tick  = req_tdata[154:126];
      item_in.retry_policy   = req_tdata[155];
      item_in.captured_stamp = req_tdata[219:156];
   end

   assign in_valid_in  = req_fire | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) item_ff   <= item_in;
      if (advance)  result_ff <= core_result;
   end

   tsst_slot_core #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = result_ff.stamp;
   assign rsp_tuser  = result_ff.status;

   // Checks
   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && out_valid_ff)
      else $error("request stalled with a free pipeline");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced item produced no result");

   a_no_silent_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("pending item lost");

endmodule

// File: rtl/tsst_csr.sv
// Configuration registers of the timestamp slot tracker behind an APB-style port.
// Depends on tsst_pkg for the register indexes and the cfg_type struct.
module tsst_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output tsst_pkg::cfg_type  cfg
);
   import tsst_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg        = cfg_ff;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_STAMPING_ENABLE:  cfg_in.stamping_enable  = csr_pwdata[0];
            REG_OVERFLOW_MARGIN:  cfg_in.overflow_margin  = csr_pwdata[15:0];
            REG_MAX_RETRIES:      cfg_in.max_retries      = csr_pwdata[7:0];
            REG_UPDATE_THRESHOLD: cfg_in.update_threshold = csr_pwdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stamping_enable  <= 1'b0;
         cfg_ff.overflow_margin  <= MARGIN_RESET;
         cfg_ff.max_retries      <= RETRIES_RESET;
         cfg_ff.update_threshold <= THRESHOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_STAMPING_ENABLE:  csr_prdata = {31'd0, cfg_ff.stamping_enable};
         REG_OVERFLOW_MARGIN:  csr_prdata = {16'd0, cfg_ff.overflow_margin};
         REG_MAX_RETRIES:      csr_prdata = {24'd0, cfg_ff.max_retries};
         REG_UPDATE_THRESHOLD: csr_prdata = cfg_ff.update_threshold;
         default:              csr_prdata = 32'd0;
      endcase
   end

endmodule

// File: rtl/tsst_slot_core.sv
// Per-slot state and the arm/poll decision of the timestamp slot tracker.
// Reads the addressed slot, decides the status and writes the slot back on fire.
// Depends on tsst_pkg.
module tsst_slot_core #(
   parameter int SLOT_COUNT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  tsst_pkg::item_type    item,
   input  tsst_pkg::cfg_type     cfg,
   output tsst_pkg::result_type  result
);
   import tsst_pkg::*;

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   // Slot state
   logic        busy_ff        [SLOT_COUNT];
   logic [63:0] start_after_ff [SLOT_COUNT];
   logic [63:0] wait_until_ff  [SLOT_COUNT];
   logic [63:0] last_stamp_ff  [SLOT_COUNT];
   logic [7:0]  retry_count_ff [SLOT_COUNT];

   logic             bad_slot;
   logic [IDX_W-1:0] idx;
   logic             cur_busy;
   logic [63:0]      cur_start;
   logic [63:0]      cur_wait;
   logic [63:0]      cur_last;
   logic [7:0]       cur_count;
   logic [7:0]       bumped;
   logic             limit_hit;
   logic [63:0]      age;
   logic             partial;
   logic [TICK_BITS-1:0] deadline;

   // Write-back controls for the addressed slot
   logic        arm_we;
   logic        free_we;
   logic        count_we;
   logic [7:0]  count_in;
   logic        last_we;
   logic [63:0] start_in;
   logic [63:0] wait_in;

   assign bad_slot  = {1'b0, item.slot} >= 5'(SLOT_COUNT);
   assign idx       = item.slot[IDX_W-1:0];
   assign cur_busy  = busy_ff[idx];
   assign cur_start = start_after_ff[idx];
   assign cur_wait  = wait_until_ff[idx];
   assign cur_last  = last_stamp_ff[idx];
   assign cur_count = retry_count_ff[idx];

   assign bumped    = cur_count + 8'd1;
   assign limit_hit = bumped >= cfg.max_retries;
   assign age       = item.now - item.captured_stamp;
   assign partial   = age > {32'd0, cfg.update_threshold};
   assign deadline  = item.retry_policy ? item.delay_to_tick : item.to_tick;
   assign start_in  = widen_tick(item.now, item.from_tick, cfg.overflow_margin);
   assign wait_in   = widen_tick(item.now, deadline, cfg.overflow_margin);

   // Decision
   always_comb begin
      result.status = ST_BADSLOT;
      result.stamp  = 64'd0;
      arm_we        = 1'b0;
      free_we       = 1'b0;
      count_we      = 1'b0;
      count_in      = 8'd0;
      last_we       = 1'b0;
      if (!bad_slot) begin
         if (item.cmd == CMD_ARM) begin
            if (!cfg.stamping_enable) begin
               result.status = ST_OFF;
            end else if (cur_busy) begin
               result.status = ST_BUSY;
            end else begin
               result.status = ST_ARMED;
               arm_we        = 1'b1;
            end
         end else begin
            if (!cur_busy) begin
               result.status = ST_IDLE;
               count_we      = 1'b1;
            end else if (item.now < cur_start) begin
               result.status = ST_RETRY;
            end else if (item.captured_stamp == cur_last) begin
               if (item.now < cur_wait) begin
                  result.status = ST_RETRY;
               end else begin
                  count_we      = 1'b1;
                  count_in      = limit_hit ? 8'd0 : bumped;
                  free_we       = limit_hit;
                  result.status = limit_hit ? ST_STALE : ST_RETRY;
               end
            end else if (partial) begin
               count_we      = 1'b1;
               count_in      = limit_hit ? 8'd0 : bumped;
               free_we       = limit_hit;
               result.status = limit_hit ? ST_PARTIAL : ST_RETRY;
            end else begin
               result.status = ST_DONE;
               result.stamp  = item.captured_stamp;
               count_we      = 1'b1;
               last_we       = 1'b1;
               free_we       = 1'b1;
            end
         end
      end
   end

   // Busy, last stamp and retry count: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            busy_ff[i]        <= 1'b0;
            last_stamp_ff[i]  <= 64'd0;
            retry_count_ff[i] <= 8'd0;
         end
      end else if (fire) begin
         if (arm_we)   busy_ff[idx]        <= 1'b1;
         if (free_we)  busy_ff[idx]        <= 1'b0;
         if (count_we) retry_count_ff[idx] <= count_in;
         if (last_we)  last_stamp_ff[idx]  <= item.captured_stamp;
      end
   end

   // Window bounds: only read once the slot has been armed
   always_ff @(posedge clock) begin
      if (fire && arm_we) begin
         start_after_ff[idx] <= start_in;
         wait_until_ff[idx]  <= wait_in;
      end
   end

   // Checks
   a_stamp_only_on_done: assert property (@(posedge clock) disable iff (reset)
      result.stamp != 64'd0 |-> result.status == ST_DONE)
      else $error("stamp driven without a done status");

   a_arm_sets_busy: assert property (@(posedge clock) disable iff (reset)
      fire && result.status == ST_ARMED |=> busy_ff[$past(idx)])
      else $error("armed slot not marked busy");

   a_finish_frees: assert property (@(posedge clock) disable iff (reset)
      fire && (result.status == ST_DONE || result.status == ST_STALE ||
               result.status == ST_PARTIAL) |=> !busy_ff[$past(idx)])
      else $error("finished slot still busy");

   a_arm_needs_enable: assert property (@(posedge clock) disable iff (reset)
      result.status == ST_ARMED |-> cfg.stamping_enable)
      else $error("slot armed while stamping is off");

endmodule

// File: tb/tx_timestamp_slot_tracker_tb.sv
// Self-checking testbench for tx_timestamp_slot_tracker: directed corner cases, then
// random arm/poll traffic over several register settings, checked against a slot predictor.
// Depends on tsst_pkg and the tracker RTL only.
module tx_timestamp_slot_tracker_tb;
   import tsst_pkg::*;

   localparam int SLOT_COUNT = 8;
   localparam logic [63:0] DIRECTED_NOW = {35'd5, 29'd1000};

   // Predicts the status and stamp of every accepted transaction from its own slot state
   class slot_status_tracker;
      bit          enable;
      bit [15:0]   margin;
      bit [7:0]    retry_limit;
      bit [31:0]   fresh_window;
      bit          busy[SLOT_COUNT];
      bit [63:0]   open_at[SLOT_COUNT];
      bit [63:0]   close_at[SLOT_COUNT];
      bit [63:0]   prev_stamp[SLOT_COUNT];
      bit [7:0]    tries[SLOT_COUNT];
      result_type  awaited_results[$];
      int          status_hits[16];
      int          mismatches;
      int          checked;

      function new();
         enable       = 1'b0;
         margin       = MARGIN_RESET;
         retry_limit  = RETRIES_RESET;
         fresh_window = THRESHOLD_RESET;
         foreach (busy[i]) begin
            busy[i]       = 1'b0;
            open_at[i]    = '0;
            close_at[i]   = '0;
            prev_stamp[i] = '0;
            tries[i]      = '0;
         end
         foreach (status_hits[i]) status_hits[i] = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void set_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_STAMPING_ENABLE:  enable       = value[0];
            REG_OVERFLOW_MARGIN:  margin       = value[15:0];
            REG_MAX_RETRIES:      retry_limit  = value[7:0];
            REG_UPDATE_THRESHOLD: fresh_window = value;
            default: ;
         endcase
      endfunction

      // Upper clock bits joined with the tick, one tick period later if it lags too far
      function bit [63:0] extend_tick(bit [63:0] now, bit [TICK_BITS-1:0] tick);
         bit [TICK_BITS-1:0] low;
         bit [63:0]          full;
         low  = now[TICK_BITS-1:0];
         full = {now[63:TICK_BITS], tick};
         if (low > tick && (low - tick) > margin) full = full + (64'd1 << TICK_BITS);
         return full;
      endfunction

      // One more failed attempt; gives up and frees the slot at the limit
      function status_type count_retry(int s, status_type give_up);
         tries[s] = tries[s] + 8'd1;
         if (tries[s] >= retry_limit) begin
            tries[s] = '0;
            busy[s]  = 1'b0;
            return give_up;
         end
         return ST_RETRY;
      endfunction

      function void note_request(item_type it);
         result_type         res;
         int                 s;
         bit [TICK_BITS-1:0] deadline;
         res.status = ST_BADSLOT;
         res.stamp  = '0;
         s = it.slot;
         if (it.slot < SLOT_COUNT) begin
            if (it.cmd == CMD_ARM) begin
               if (!enable) begin
                  res.status = ST_OFF;
               end else if (busy[s]) begin
                  res.status = ST_BUSY;
               end else begin
                  deadline    = it.retry_policy ? it.delay_to_tick : it.to_tick;
                  busy[s]     = 1'b1;
                  open_at[s]  = extend_tick(it.now, it.from_tick);
                  close_at[s] = extend_tick(it.now, deadline);
                  res.status  = ST_ARMED;
               end
            end else begin
               if (!busy[s]) begin
                  tries[s]   = '0;
                  res.status = ST_IDLE;
               end else if (it.now < open_at[s]) begin
                  res.status = ST_RETRY;
               end else if (it.captured_stamp == prev_stamp[s]) begin
                  res.status = (it.now < close_at[s]) ? ST_RETRY : count_retry(s, ST_STALE);
               end else if (it.now - it.captured_stamp > {32'd0, fresh_window}) begin
                  res.status = count_retry(s, ST_PARTIAL);
               end else begin
                  tries[s]      = '0;
                  prev_stamp[s] = it.captured_stamp;
                  busy[s]       = 1'b0;
                  res.stamp     = it.captured_stamp;
                  res.status    = ST_DONE;
               end
            end
         end
         awaited_results.push_back(res);
      endfunction

      function void check_response(logic [3:0] status, logic [63:0] stamp);
         result_type want;
         if (awaited_results.size() == 0) begin
            $error("unexpected result: status %0d stamp %h", status, stamp);
            mismatches++;
            return;
         end
         want = awaited_results.pop_front();
         checked++;
         status_hits[want.status]++;
         if (status !== want.status) begin
            $error("status mismatch: expected %0d actual %0d", want.status, status);
            mismatches++;
         end
         if (stamp !== want.stamp) begin
            $error("stamp mismatch: expected %h actual %h", want.stamp, stamp);
            mismatches++;
         end
      endfunction
   endclass

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [223:0] req_tdata   = '0;
   logic         req_tuser   = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [63:0]  rsp_tdata;
   logic [3:0]   rsp_tuser;
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [3:0]   csr_paddr   = '0;
   logic [31:0]  csr_pwdata  = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   slot_status_tracker tracker;
   logic [63:0]        wall_clock = '0;
   int                 burst_left = 0;
   logic [31:0]        rx_cycle   = '0;

   tx_timestamp_slot_tracker #(.SLOT_COUNT(SLOT_COUNT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Result side: check each transaction, then stall on a rotating pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_response(rsp_tuser, rsp_tdata);
      rx_cycle <= rx_cycle + 1;
      case (rx_cycle[9:8])
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= ($urandom_range(0, 1) == 1);
         2'd2:    rsp_tready <= ((rx_cycle % 7) < 3);
         default: rsp_tready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // Sender: holds valid until the block takes the transaction
   task automatic send_item(input item_type it);
      req_tvalid <= 1'b1;
      req_tuser  <= it.cmd;
      req_tdata  <= {4'b0, it.captured_stamp, it.retry_policy, it.delay_to_tick,
                     it.to_tick, it.from_tick, it.now, it.slot};
      do @(posedge clock); while (!req_tready);
      tracker.note_request(it);
   endtask

   // APB write: setup cycle, then access cycle
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.set_register(idx, value);
   endtask

   // Stop sending until every outstanding result is back, plus pipeline slack
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (tracker.awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic item_type build_item(cmd_type cmd, logic [3:0] slot, logic [63:0] now,
                                           logic [TICK_BITS-1:0] from_tick,
                                           logic [TICK_BITS-1:0] to_tick,
                                           logic [TICK_BITS-1:0] delay_to_tick,
                                           logic retry_policy, logic [63:0] cap);
      item_type it;
      it.cmd            = cmd;
      it.slot           = slot;
      it.now            = now;
      it.from_tick      = from_tick;
      it.to_tick        = to_tick;
      it.delay_to_tick  = delay_to_tick;
      it.retry_policy   = retry_policy;
      it.captured_stamp = cap;
      return it;
   endfunction

   // Mostly well-formed arm/poll traffic aimed at the slot windows; some pure noise
   function automatic item_type random_item();
      item_type    it;
      int unsigned roll;
      int unsigned pick;
      int unsigned s;
      int unsigned spread;
      roll              = $urandom_range(0, 99);
      it.cmd            = cmd_type'($urandom_range(0, 1));
      it.slot           = 4'($urandom);
      it.now            = {$urandom, $urandom};
      it.from_tick      = TICK_BITS'($urandom);
      it.to_tick        = TICK_BITS'($urandom);
      it.delay_to_tick  = TICK_BITS'($urandom);
      it.retry_policy   = 1'($urandom_range(0, 1));
      it.captured_stamp = {$urandom, $urandom};
      if (roll < 6) return it;
      wall_clock = wall_clock + 64'($urandom_range(0, 400));
      it.now     = wall_clock;
      s          = (roll < 12) ? $urandom_range(SLOT_COUNT, 15) : $urandom_range(0, SLOT_COUNT - 1);
      it.slot    = 4'(s);
      if (s >= SLOT_COUNT) return it;
      if (!tracker.busy[s]) it.cmd = ($urandom_range(0, 3) != 0) ? CMD_ARM : CMD_POLL;
      else                  it.cmd = ($urandom_range(0, 4) != 0) ? CMD_POLL : CMD_ARM;
      if (it.cmd == CMD_ARM) begin
         // start tick ahead, slightly behind, right at the wrap margin, or anywhere
         case ($urandom_range(0, 3))
            0: it.from_tick = it.now[TICK_BITS-1:0] + TICK_BITS'($urandom_range(0, 600));
            1: it.from_tick = it.now[TICK_BITS-1:0]
                              - TICK_BITS'($urandom_range(0, tracker.margin));
            2: it.from_tick = it.now[TICK_BITS-1:0] - TICK_BITS'(tracker.margin)
                              - TICK_BITS'($urandom_range(0, 1));
            default: ;
         endcase
         it.to_tick       = it.from_tick + TICK_BITS'($urandom_range(0, 3000));
         it.delay_to_tick = it.from_tick + TICK_BITS'($urandom_range(0, 3000));
      end else if (tracker.busy[s]) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       it.now = tracker.open_at[s] - 64'($urandom_range(1, 200));
            1, 2, 3: it.now = tracker.open_at[s] + 64'($urandom_range(0, 500));
            4:       it.now = tracker.close_at[s];
            default: it.now = tracker.close_at[s] + 64'($urandom_range(0, 200));
         endcase
         spread = (tracker.fresh_window < 5000) ? tracker.fresh_window : 5000;
         pick   = $urandom_range(0, 99);
         if (pick < 35)      it.captured_stamp = tracker.prev_stamp[s];
         else if (pick < 60) it.captured_stamp = it.now - 64'($urandom_range(0, spread));
         else if (pick < 70) it.captured_stamp = it.now - {32'd0, tracker.fresh_window}
                                                 - 64'($urandom_range(0, 1));
         else if (pick < 95) it.captured_stamp = it.now - {32'd0, tracker.fresh_window}
                                                 - 64'd1 - 64'($urandom_range(0, 3000));
      end
      return it;
   endfunction

   // One register setting followed by bursty random traffic
   task automatic run_phase(input logic enable, input logic [15:0] margin,
                            input logic [7:0] retries, input logic [31:0] threshold,
                            input logic [63:0] base_now, input int count);
      wait_for_quiet();
      write_reg(REG_STAMPING_ENABLE, {31'd0, enable});
      write_reg(REG_OVERFLOW_MARGIN, {16'd0, margin});
      write_reg(REG_MAX_RETRIES, {24'd0, retries});
      write_reg(REG_UPDATE_THRESHOLD, threshold);
      wall_clock = base_now;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
         end
         send_item(random_item());
         burst_left--;
      end
   endtask

   initial begin
      string      mix;
      status_type code;
      tracker = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: stamping off, bad slot numbers
      send_item(build_item(CMD_ARM, 4'd0, DIRECTED_NOW, 29'd900, 29'd899, 29'd7, 1'b0, 64'd0));
      send_item(build_item(CMD_POLL, 4'd0, DIRECTED_NOW, '0, '0, '0, 1'b0, 64'd0));
      send_item(build_item(CMD_ARM, 4'd15, DIRECTED_NOW, '0, '0, '0, 1'b0, 64'd0));
      send_item(build_item(CMD_POLL, 4'd8, DIRECTED_NOW, '0, '0, '0, 1'b0, 64'd0));
      wait_for_quiet();
      write_reg(REG_STAMPING_ENABLE, 32'd1);

      // Start tick lags by exactly the margin, deadline by one more (wraps)
      send_item(build_item(CMD_ARM, 4'd0, DIRECTED_NOW, 29'd900, 29'd899, 29'd7, 1'b0, 64'd0));
      send_item(build_item(CMD_ARM, 4'd0, DIRECTED_NOW, 29'd900, 29'd899, 29'd7, 1'b0, 64'd0));
      // Retry policy picks the delayed deadline; window not open yet
      send_item(build_item(CMD_ARM, 4'd1, DIRECTED_NOW, 29'd1050, 29'd0, 29'd1200, 1'b1, 64'd0));
      send_item(build_item(CMD_POLL, 4'd1, DIRECTED_NOW, '0, '0, '0, 1'b0, 64'd0));
      // Stale stamp before and at the deadline, then a fresh one at the threshold
      send_item(build_item(CMD_POLL, 4'd0, DIRECTED_NOW, '0, '0, '0, 1'b0, 64'd0));
      send_item(build_item(CMD_POLL, 4'd0, tracker.close_at[0], '0, '0, '0, 1'b0, 64'd0));
      send_item(build_item(CMD_POLL, 4'd0, tracker.close_at[0], '0, '0, '0, 1'b0,
                           tracker.close_at[0] - 64'd1000));
      send_item(build_item(CMD_POLL, 4'd0, DIRECTED_NOW, '0, '0, '0, 1'b0, 64'd0));
      // Clock at the top of its range: widened start wraps past zero
      send_item(build_item(CMD_ARM, 4'd2, 64'hFFFF_FFFF_FFFF_FFF0, 29'd0, 29'h1FFF_FFFF,
                           29'd0, 1'b0, 64'd0));
      send_item(build_item(CMD_POLL, 4'd2, '1, '0, '0, '0, 1'b0, 64'hFFFF_FFFF_FFFF_FC16));
      // Tick above the low clock bits never wraps
      send_item(build_item(CMD_ARM, 4'd7, {35'd7, 29'd0}, 29'h1FFF_FFFF, 29'h1FFF_FFFF,
                           29'h1FFF_FFFF, 1'b1, 64'd0));
      send_item(build_item(CMD_POLL, 4'd7, '1, '0, '0, '0, 1'b0, '1));
      wait_for_quiet();
      write_reg(REG_MAX_RETRIES, 32'd1);
      // Retry limit reached: stale fail and partial fail
      send_item(build_item(CMD_POLL, 4'd2, '1, '0, '0, '0, 1'b0, 64'd0));
      send_item(build_item(CMD_ARM, 4'd3, DIRECTED_NOW, 29'd1000, 29'd1000, 29'd0, 1'b0, 64'd0));
      send_item(build_item(CMD_POLL, 4'd3, DIRECTED_NOW, '0, '0, '0, 1'b0,
                           DIRECTED_NOW - 64'd1001));

      // Random traffic over several settings, extremes included
      run_phase(1'b1, 16'd100, 8'd3, 32'd1000, 64'h0000_0000_0000_0000, 320);
      run_phase(1'b1, 16'd0, 8'd1, 32'd0, 64'h0000_0042_1FFF_F000, 300);
      run_phase(1'b1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_0000, 300);
      run_phase(1'b0, 16'd500, 8'd5, 32'd50, 64'h1234_5678_0000_0000, 150);
      run_phase(1'b1, 16'd1234, 8'd0, 32'd2000, 64'hFFFF_FFFF_FFF0_0000, 350);
      run_phase(1'b1, 16'd100, 8'd10, 32'd1000, 64'h0000_1000_0000_0000, 400);

      // Drain with a bound, then report anything still owed
      req_tvalid <= 1'b0;
      for (int n = 0; n < 5000 && tracker.awaited_results.size() != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.awaited_results.size() != 0) begin
         $error("%0d results never arrived", tracker.awaited_results.size());
         tracker.mismatches++;
      end

      mix = "";
      for (int k = 0; k <= 8; k++) begin
         code = status_type'(k);
         mix  = {mix, $sformatf("%s=%0d ", code.name(), tracker.status_hits[k])};
      end
      $display("Checked %0d results: directed corners plus six register settings.",
               tracker.checked);
      $display("Result mix: %s", mix);
      if (tracker.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #3200000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
rtl/tsst_pkg.sv
rtl/tsst_csr.sv
rtl/tsst_slot_core.sv
rtl/tx_timestamp_slot_tracker.sv
tb/tx_timestamp_slot_tracker_tb.sv
